>>> sv/owkl_pkg.sv
// Shared widths, constants, register indexes and types of the omni wheel kinematics limiter.
package owkl_pkg;

	// Field and register widths
	localparam int IN_W       = 16;
	localparam int LIM_W      = 15;
	localparam int RAD_W      = 16;
	localparam int FRAC_BITS  = 15;
	localparam int LANES      = 3;

	// Internal datapath widths: raw wheel sums on a 2^-15 scale stay below 2^39
	localparam int YAWP_W     = RAD_W + IN_W + 1;
	localparam int SYP_W      = 32;
	localparam int RAW_W      = 41;
	localparam int MAG_W      = 40;
	localparam int SPLIT_W    = 20;
	localparam int PP_W       = SPLIT_W + LIM_W;
	localparam int NUM_W      = MAG_W + LIM_W;
	localparam int QB         = LIM_W;

	// Q1.15 coefficient sqrt(3)/2, rounded to nearest
	localparam logic [FRAC_BITS-1:0] COEF_SQRT3H = 15'd28378;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MAX_SPEED  = 8'd0;
	localparam cfg_idx_t REG_ROT_RADIUS = 8'd1;

	localparam logic [LIM_W-1:0] LIM_RESET = 15'd8500;
	localparam logic [RAD_W-1:0] RAD_RESET = 16'd256;

	// Per-item data that rides alongside the division
	typedef struct packed {
		logic                        limited;
		logic [LANES-1:0]            neg;
		logic [LANES-1:0][QB-1:0]    unl;
	} side_t;

endpackage

>>> sv/omni_wheel_kinematics_limiter.sv
// Top level: three-wheel omni inverse kinematics with proportional speed limiting.
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | s_axis_tvalid/tready   | tdata: vel_x, vel_y, yaw_rate
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: wheel_a, wheel_b, wheel_c; tuser: was_limited
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One command per cycle while the output is not stalled; six front stages (products, sums,
// magnitudes, peak, limit test with partial products, numerator), fifteen divider
// stages (one quotient bit each) and the output register.
// Reset clears every valid bit and loads the limit (8500) and radius (1.0).
// Each stage holds while the stage after it is full and stalled; empty stages close
// up, so commands are still taken while a result waits at the output.
// cfg_ready is always high.
module omni_wheel_kinematics_limiter import owkl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// Command stream
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [3*IN_W-1:0]       s_axis_tdata,   // [15:0] vel_x, [31:16] vel_y, [47:32] yaw_rate
	// Wheel speed stream
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [3*IN_W-1:0]       m_axis_tdata,   // [15:0] wheel_a, [31:16] wheel_b, [47:32] wheel_c
	output logic                    m_axis_tuser,   // [0] was_limited
	// Register writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  cfg_idx_t                cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers
	logic [LIM_W-1:0] max_q;
	logic [RAD_W-1:0] rad_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= LIM_RESET;
			rad_q <= RAD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_SPEED:  max_q <= cfg_data[LIM_W-1:0];
				REG_ROT_RADIUS: rad_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic div_in_ready, div_out_valid, div_out_ready;
	logic out_v_q;

	assign en_s6 = !v_s6 || div_in_ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: yaw and sideways products
	logic signed [IN_W-1:0]   vel_x, vel_y, yaw_rate;
	logic signed [YAWP_W-1:0] yaw_p;
	logic signed [SYP_W-1:0]  sy_p;
	logic [IN_W-1:0]          vx_s1;
	logic [YAWP_W-1:0]        yawp_s1;
	logic [SYP_W-1:0]         syp_s1;

	assign vel_x    = s_axis_tdata[IN_W-1:0];
	assign vel_y    = s_axis_tdata[2*IN_W-1:IN_W];
	assign yaw_rate = s_axis_tdata[3*IN_W-1:2*IN_W];
	assign yaw_p    = $signed({1'b0, rad_q}) * yaw_rate;
	assign sy_p     = $signed({1'b0, COEF_SQRT3H}) * vel_y;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			vx_s1   <= vel_x;
			yawp_s1 <= yaw_p;
			syp_s1  <= sy_p;
		end
	end

	// Stage 2: raw wheel sums on the 2^-15 scale
	logic [RAW_W-1:0] vx_sh15, vx_sh14, yaw_sh7, sy_ext;
	logic [LANES-1:0][RAW_W-1:0] raw_s2;

	assign vx_sh15 = {{(RAW_W-IN_W-15){vx_s1[IN_W-1]}}, vx_s1, 15'b0};
	assign vx_sh14 = {{(RAW_W-IN_W-14){vx_s1[IN_W-1]}}, vx_s1, 14'b0};
	assign yaw_sh7 = {{(RAW_W-YAWP_W-7){yawp_s1[YAWP_W-1]}}, yawp_s1, 7'b0};
	assign sy_ext  = {{(RAW_W-SYP_W){syp_s1[SYP_W-1]}}, syp_s1};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			raw_s2[0] <= vx_sh15 - yaw_sh7;
			raw_s2[1] <= '0 - vx_sh14 - sy_ext - yaw_sh7;
			raw_s2[2] <= sy_ext - vx_sh14 - yaw_sh7;
		end
	end

	// Stage 3: sign and magnitude
	logic [LANES-1:0][MAG_W-1:0] mag_s3;
	logic [LANES-1:0]            neg_s3;
	logic [LANES-1:0][RAW_W-1:0] raw_neg;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			raw_neg[l] = '0 - raw_s2[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int l = 0; l < LANES; l++) begin
				neg_s3[l] <= raw_s2[l][RAW_W-1];
				mag_s3[l] <= raw_s2[l][RAW_W-1] ? raw_neg[l][MAG_W-1:0]
				                                : raw_s2[l][MAG_W-1:0];
			end
		end
	end

	// Stage 4: peak magnitude
	logic [MAG_W-1:0]            max_ab, peak;
	logic [MAG_W-1:0]            peak_s4;
	logic [LANES-1:0][MAG_W-1:0] mag_s4;
	logic [LANES-1:0]            neg_s4;

	assign max_ab = (mag_s3[0] >= mag_s3[1]) ? mag_s3[0] : mag_s3[1];
	assign peak   = (max_ab >= mag_s3[2]) ? max_ab : mag_s3[2];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			peak_s4 <= peak;
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
		end
	end

	// Stage 5: limit test, split products of magnitude and limit
	logic [MAG_W-1:0]           lim_scaled;
	logic [LANES-1:0][PP_W-1:0] lo_s5, hi_s5;
	logic [MAG_W-1:0]           peak_s5;
	side_t                      side_s5;

	assign lim_scaled = {{(MAG_W-LIM_W-FRAC_BITS){1'b0}}, max_q, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		if (en_s5) begin
			peak_s5         <= peak_s4;
			side_s5.limited <= peak_s4 > lim_scaled;
			side_s5.neg     <= neg_s4;
			for (int l = 0; l < LANES; l++) begin
				lo_s5[l]       <= mag_s4[l][SPLIT_W-1:0] * max_q;
				hi_s5[l]       <= mag_s4[l][MAG_W-1:SPLIT_W] * max_q;
				side_s5.unl[l] <= mag_s4[l][FRAC_BITS+QB-1:FRAC_BITS];
			end
		end
	end

	// Stage 6: join partial products into the numerator
	logic [LANES-1:0][NUM_W-1:0] num_s6;
	logic [MAG_W-1:0]            peak_s6;
	side_t                       side_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			peak_s6 <= peak_s5;
			side_s6 <= side_s5;
			for (int l = 0; l < LANES; l++) begin
				num_s6[l] <= {hi_s5[l], {SPLIT_W{1'b0}}} + {{(NUM_W-PP_W){1'b0}}, lo_s5[l]};
			end
		end
	end

	// Scale by limit over peak
	logic [LANES-1:0][QB-1:0] div_quo;
	side_t                    div_side;

	owkl_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_ready  (div_in_ready),
		.in_num    (num_s6),
		.in_den    (peak_s6),
		.in_side   (side_s6),
		.out_valid (div_out_valid),
		.out_ready (div_out_ready),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	// Output register: pick scaled or plain speed, restore sign
	logic [LANES-1:0][IN_W-1:0] wheel_q;
	logic [LANES-1:0][IN_W-1:0] wheel_nx;
	logic                       lim_q;

	assign div_out_ready = !out_v_q || m_axis_tready;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [IN_W-1:0] m;
			m = {1'b0, div_side.limited ? div_quo[l] : div_side.unl[l]};
			wheel_nx[l] = div_side.neg[l] ? ('0 - m) : m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (div_out_ready) begin
			out_v_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out_ready) begin
			wheel_q <= wheel_nx;
			lim_q   <= div_side.limited;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {wheel_q[2], wheel_q[1], wheel_q[0]};
	assign m_axis_tuser  = lim_q;

`ifndef NO_ASSERTIONS
	// Peak bounds every lane magnitude
	a_peak_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (peak_s4 >= mag_s4[0]) && (peak_s4 >= mag_s4[1]) && (peak_s4 >= mag_s4[2]))
		else $error("peak below a lane magnitude");

	// Peak is one of the lane magnitudes
	a_peak_member: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (peak_s4 == mag_s4[0]) || (peak_s4 == mag_s4[1]) || (peak_s4 == mag_s4[2]))
		else $error("peak matches no lane magnitude");

	// A free output lets every stage advance
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output was free");
`endif

endmodule

>>> sv/owkl_divider.sv
// Pipelined three-lane restoring divider, one quotient bit per stage, shared divisor.
module owkl_divider import owkl_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [LANES-1:0][NUM_W-1:0]     in_num,
	input  logic [MAG_W-1:0]                in_den,
	input  side_t                           in_side,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [LANES-1:0][QB-1:0]        out_quo,
	output side_t                           out_side
);

	logic                           vld_s  [QB];
	logic                           en_s   [QB];
	logic [LANES-1:0][NUM_W-1:0]    rem_s  [QB];
	logic [LANES-1:0][QB-1:0]       quo_s  [QB];
	logic [MAG_W-1:0]               den_s  [QB];
	side_t                          side_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int BIT = QB - 1 - j;

		logic [LANES-1:0][NUM_W-1:0] rem_in;
		logic [LANES-1:0][NUM_W-1:0] rem_nx;
		logic [LANES-1:0][QB-1:0]    quo_in;
		logic [LANES-1:0][QB-1:0]    quo_nx;
		logic [MAG_W-1:0]            den_in;
		side_t                       side_in;
		logic                        v_in;
		logic                        en_nx;
		logic [NUM_W-1:0]            dsh;

		// Select the stage input
		if (j == 0) begin : g_first
			assign rem_in  = in_num;
			assign quo_in  = '0;
			assign den_in  = in_den;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign den_in  = den_s[j-1];
			assign side_in = side_s[j-1];
			assign v_in    = vld_s[j-1];
		end

		// Advance when empty or when the next stage takes our transaction
		if (j == QB - 1) begin : g_last
			assign en_nx = out_ready;
		end else begin : g_mid
			assign en_nx = en_s[j+1];
		end
		assign en_s[j] = !vld_s[j] || en_nx;

		// Trial subtract of the divisor aligned to this quotient bit
		assign dsh = {{(NUM_W-MAG_W){1'b0}}, den_in} << BIT;

		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int l = 0; l < LANES; l++) begin
				if (rem_in[l] >= dsh) begin
					rem_nx[l]      = rem_in[l] - dsh;
					quo_nx[l][BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en_s[j]) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[j]) begin
				rem_s[j]  <= rem_nx;
				quo_s[j]  <= quo_nx;
				den_s[j]  <= den_in;
				side_s[j] <= side_in;
			end
		end
	end

	assign in_ready  = en_s[0];
	assign out_valid = vld_s[QB-1];
	assign out_quo   = quo_s[QB-1];
	assign out_side  = side_s[QB-1];

`ifndef NO_ASSERTIONS
	// A scaled item never carries a zero divisor
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_side.limited |-> in_den != '0)
		else $error("limited transaction entered divider with zero divisor");

	// After the last step every lane remainder is below the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QB-1] && side_s[QB-1].limited |->
			(rem_s[QB-1][0] < {{(NUM_W-MAG_W){1'b0}}, den_s[QB-1]}) &&
			(rem_s[QB-1][1] < {{(NUM_W-MAG_W){1'b0}}, den_s[QB-1]}) &&
			(rem_s[QB-1][2] < {{(NUM_W-MAG_W){1'b0}}, den_s[QB-1]}))
		else $error("divider remainder not reduced below divisor");

	// A free output lets the whole divider move
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("divider stalled while output was free");
`endif

endmodule

>>> verif/wheel_speed_checker.sv
// Checker for the omni wheel limiter: watches the three channels, predicts wheel speeds and compares.
module wheel_speed_checker import owkl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [3*IN_W-1:0]     s_axis_tdata,   // [15:0] vel_x, [31:16] vel_y, [47:32] yaw_rate
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [3*IN_W-1:0]     m_axis_tdata,   // [15:0] wheel_a, [31:16] wheel_b, [47:32] wheel_c
	input  logic                  m_axis_tuser,   // [0] was_limited
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    outstanding
);

	// Q1.15 matrix coefficients
	localparam longint Q_ONE     = 32768;
	localparam longint Q_HALF    = 16384;
	localparam longint Q_SQRT3_2 = 28378;

	typedef struct packed {
		logic signed [IN_W-1:0] wheel_a;
		logic signed [IN_W-1:0] wheel_b;
		logic signed [IN_W-1:0] wheel_c;
		logic                   limited;
	} wheel_set_t;

	wheel_set_t       speeds_q[$];
	wheel_set_t       want;
	logic [LIM_W-1:0] speed_limit;
	logic [RAD_W-1:0] radius;
	int               mismatches;

	// Map one chassis command onto the three wheels and scale down past the limit
	function automatic wheel_set_t wheel_speeds(input logic signed [IN_W-1:0] vx,
			input logic signed [IN_W-1:0] vy, input logic signed [IN_W-1:0] yaw_in,
			input logic [LIM_W-1:0] lim, input logic [RAD_W-1:0] rad);
		longint     x, y, w, r, l, yaw, peak, mag;
		longint     sums [LANES];
		longint     v [LANES];
		logic       limited;
		wheel_set_t res;
		int         i;
		x = vx;
		y = vy;
		w = yaw_in;
		r = rad;
		l = lim;
		// yaw term moved from Q8.8 onto the common 2^-15 scale
		yaw = r * w * 128;
		sums[0] = x * Q_ONE - yaw;
		sums[1] = -Q_HALF * x - Q_SQRT3_2 * y - yaw;
		sums[2] = -Q_HALF * x + Q_SQRT3_2 * y - yaw;
		peak = 0;
		for (i = 0; i < LANES; i++) begin
			mag = (sums[i] < 0) ? -sums[i] : sums[i];
			if (mag > peak)
				peak = mag;
		end
		limited = peak > l * Q_ONE;
		// division truncates toward zero; results stay within +-limit, so no saturation
		for (i = 0; i < LANES; i++)
			v[i] = limited ? (sums[i] * l) / peak : sums[i] / Q_ONE;
		res.wheel_a = v[0][IN_W-1:0];
		res.wheel_b = v[1][IN_W-1:0];
		res.wheel_c = v[2][IN_W-1:0];
		res.limited = limited;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [IN_W-1:0] exp_val,
			input logic [IN_W-1:0] got_val);
		if (exp_val !== got_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
				$signed(exp_val), $signed(got_val));
		end
	endtask

	// Track register writes, queue predictions per command, compare per result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit = LIM_RESET;
			radius      = RAD_RESET;
			speeds_q.delete();
			mismatches  = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (speeds_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with no command waiting, expected none, got %h/%b",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = speeds_q.pop_front();
					check_field("wheel_a", want.wheel_a, m_axis_tdata[IN_W-1:0]);
					check_field("wheel_b", want.wheel_b, m_axis_tdata[2*IN_W-1:IN_W]);
					check_field("wheel_c", want.wheel_c, m_axis_tdata[3*IN_W-1:2*IN_W]);
					check_field("was_limited", IN_W'(want.limited), IN_W'(m_axis_tuser));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				speeds_q.push_back(wheel_speeds(s_axis_tdata[IN_W-1:0],
					s_axis_tdata[2*IN_W-1:IN_W], s_axis_tdata[3*IN_W-1:2*IN_W],
					speed_limit, radius));
			// keep only the low bits of the limit word and the whole radius word; drop unknown indexes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_SPEED:  speed_limit = cfg_data[LIM_W-1:0];
					REG_ROT_RADIUS: radius = cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
			errors      <= mismatches;
			outstanding <= speeds_q.size();
		end
	end

endmodule

>>> verif/tb.sv
// Testbench top for the omni wheel limiter: clock, reset, commands, register writes and verdict.
module tb import owkl_pkg::*;;

	localparam int       HALF_PERIOD  = 10;
	localparam int       LATENCY      = 22;
	localparam int       WATCHDOG     = 3000;
	localparam int       HOLD_OFF     = 400;
	localparam int       PHASES       = 12;
	localparam int       PHASE_ITEMS  = 150;
	localparam cfg_idx_t REG_UNUSED_LO = 8'd2;
	localparam cfg_idx_t REG_UNUSED_HI = 8'hFF;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [3*IN_W-1:0]     s_axis_tdata;   // [15:0] vel_x, [31:16] vel_y, [47:32] yaw_rate
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [3*IN_W-1:0]     m_axis_tdata;   // [15:0] wheel_a, [31:16] wheel_b, [47:32] wheel_c
	logic                  m_axis_tuser;   // [0] was_limited
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int outstanding;
	int idle_cycles = 0;
	bit tx_gaps;
	bit rx_gaps;
	bit hold_off_req;

	omni_wheel_kinematics_limiter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	wheel_speed_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Mix corner values, speeds near typical limits and full-range noise
	function automatic logic [IN_W-1:0] pick_speed();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: return 16'h8000;
				1: return 16'h7FFF;
				2: return 16'h0000;
				3: return 16'hFFFF;
				default: return 16'h0001;
			endcase
		end
		if (r < 5)
			return 16'($urandom_range(0, 24000) - 12000);
		return 16'($urandom);
	endfunction

	// Offer one command and hold it until the transaction completes
	task automatic send_cmd(input logic [IN_W-1:0] vx, input logic [IN_W-1:0] vy,
			input logic [IN_W-1:0] w);
		int gap;
		gap = tx_gaps ? gap_len() : 0;
		s_axis_tdata  <= {w, vy, vx};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop the command valid and wait until every wheel result has come back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Receiver: steady ready, random stalls, or one long hold-off on request
	initial begin
		int n;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if (!rx_gaps) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				n = gap_len();
				if (n > 0) begin
					m_axis_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("** omni_wheel_kinematics_limiter: FAILED **");
			$finish;
		end
	end

	// Stimulus: directed corners, then phases of random commands under varied settings
	initial begin
		int ph;
		int i;
		logic [CFG_DATA_W-1:0] lim_word;
		logic [CFG_DATA_W-1:0] rad_word;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_MAX_SPEED;
		cfg_data      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero command, peak exactly at and just past the limit, extremes
		send_cmd(16'd0, 16'd0, 16'd0);
		send_cmd(16'd8500, 16'd0, 16'd0);
		send_cmd(16'd8501, 16'd0, 16'd0);
		send_cmd(16'd0, 16'd0, 16'd8500);
		send_cmd(16'd0, 16'd0, -16'sd8501);
		send_cmd(16'd0, 16'h7FFF, 16'd0);
		send_cmd(16'd0, 16'h8000, 16'd0);
		send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_cmd(16'h8000, 16'h8000, 16'h8000);
		send_cmd(16'h7FFF, 16'h8000, 16'h7FFF);
		send_cmd(16'h8000, 16'h7FFF, 16'h8000);
		send_cmd(16'd1, 16'd1, 16'd1);
		send_cmd(16'hFFFF, 16'hFFFF, 16'hFFFF);

		// Zero limit: anything nonzero collapses to zero and is flagged
		wait_idle();
		write_reg(REG_MAX_SPEED, 16'd0);
		send_cmd(16'd0, 16'd0, 16'd0);
		send_cmd(16'd1, 16'd0, 16'd0);
		send_cmd(16'd0, 16'd0, 16'hFFFF);
		send_cmd(16'd5, 16'hFFF9, 16'd3);

		// Over-wide limit word keeps its low bits; largest radius
		wait_idle();
		write_reg(REG_MAX_SPEED, 16'hFFFF);
		write_reg(REG_ROT_RADIUS, 16'hFFFF);
		send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_cmd(16'h8000, 16'h8000, 16'h8000);

		// Writes to unknown indexes must leave both registers alone
		wait_idle();
		write_reg(REG_UNUSED_LO, 16'h1234);
		write_reg(REG_UNUSED_HI, 16'hFFFF);
		write_reg(REG_ROT_RADIUS, 16'd0);
		send_cmd(16'd100, 16'hFF00, 16'h7FFF);

		// Random phases
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph % 6)
				0: begin lim_word = 16'($urandom); rad_word = 16'($urandom); end
				1: begin lim_word = 16'd0;         rad_word = 16'hFFFF;       end
				2: begin lim_word = 16'h7FFF;      rad_word = 16'd0;          end
				3: begin lim_word = 16'd1;         rad_word = 16'd256;        end
				4: begin lim_word = 16'd8500;      rad_word = 16'd256;        end
				default: begin
					lim_word = 16'($urandom_range(0, 12000));
					rad_word = 16'($urandom_range(0, 1024));
				end
			endcase
			write_reg(REG_MAX_SPEED, lim_word);
			write_reg(REG_ROT_RADIUS, rad_word);
			if (ph % 6 == 3)
				write_reg(cfg_idx_t'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
					16'($urandom));
			tx_gaps = (ph % 3 == 1);
			rx_gaps = (ph % 3 != 0);
			// Stall the output for a long stretch while commands keep being offered at the input
			if (ph == 5)
				hold_off_req = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_cmd(pick_speed(), pick_speed(), pick_speed());
		end

		wait_idle();
		repeat (LATENCY + 8) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("** omni_wheel_kinematics_limiter: PASSED **");
		else
			$display("** omni_wheel_kinematics_limiter: FAILED **");
		$finish;
	end

endmodule
